### rtl/psrl_pkg.sv
// ----------------------------------------------------------------------------
// psrl_pkg
// Shared types and constants for the per-source request rate limiter.
// ----------------------------------------------------------------------------
package psrl_pkg;

  // Verdict codes
  localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
  localparam logic [1:0] VERDICT_LIMITED   = 2'd1;
  localparam logic [1:0] VERDICT_UNTRACKED = 2'd2;

  // Register indexes (byte address bit 2)
  localparam logic [0:0] REG_WINDOW = 1'b0;
  localparam logic [0:0] REG_LIMIT  = 1'b1;

  // Register reset values
  localparam logic [31:0] WINDOW_RESET = 32'd60;
  localparam logic [15:0] LIMIT_RESET  = 16'd100;

  // Saturation value of the per-source count
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Configuration handed from the register file to the datapath
  typedef struct packed {
    logic [31:0] window_seconds;
    logic [15:0] request_limit;
  } psrl_cfg_t;

  // Per-entry payload kept in the data memory
  typedef struct packed {
    logic [15:0] count;
    logic [31:0] window_start;
  } psrl_entry_t;

  // Lookup sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_MISS
  } psrl_state_t;

endpackage

### rtl/psrl_regs.sv
// ----------------------------------------------------------------------------
// psrl_regs
// APB-style configuration registers: window length and request limit.
// ----------------------------------------------------------------------------
module psrl_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output psrl_pkg::psrl_cfg_t  cfg
);
  import psrl_pkg::*;

  logic [0:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[2:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Hold the registers, update on a completed write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_seconds <= WINDOW_RESET;
      cfg.request_limit  <= LIMIT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_WINDOW: cfg.window_seconds <= pwdata;
        REG_LIMIT:  cfg.request_limit  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_sel)
      REG_WINDOW: prdata = cfg.window_seconds;
      REG_LIMIT:  prdata = {16'd0, cfg.request_limit};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

### rtl/per_source_request_rate_limiter.sv
// ----------------------------------------------------------------------------
// per_source_request_rate_limiter
// Fixed-window rate limiter over a table of tracked sources held in memory.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                               Transfer
//  --------  ---------  ------------------------------------  -------------------
//  request   in         start, busy, source_address,          start && !busy
//                       arrival_time
//  result    out        done, verdict, request_count          done (one cycle)
//  config    in         psel, penable, pwrite, paddr, pwdata, psel&&penable&&pwrite
//                       prdata, pready
//
//  The tag scan reads one entry of the source memory at a time (the read
//  is registered) and compares its tag, from position 0 up, so a hit at
//  position m scans m+1 entries and a miss scans all n entries in use;
//  the next request is accepted only after the lookup has finished.
//  Reset is synchronous; it empties the table through the fill count, so no
//  clearing pass is needed and a request is accepted right after reset.
//  The result strobe lasts one cycle and cannot be stalled by the receiver.
//
module per_source_request_rate_limiter #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        start,
  output logic        busy,
  input  logic [31:0] source_address,
  input  logic [31:0] arrival_time,
  // result
  output logic        done,
  output logic [1:0]  verdict,
  output logic [15:0] request_count,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import psrl_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

  psrl_cfg_t cfg;

  psrl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Memories: source tag and per-entry count/window start
  logic [31:0]  src_mem  [TABLE_ENTRIES];
  psrl_entry_t  data_mem [TABLE_ENTRIES];

  psrl_state_t  state, state_next;
  logic [31:0]  req_src;
  logic [31:0]  req_time;
  logic [IDX_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] used, used_next;

  logic [31:0]  rd_src;
  psrl_entry_t  rd_data;

  logic             src_we;
  logic             data_we;
  logic [IDX_W-1:0] wr_addr;
  psrl_entry_t      wr_data;

  logic             done_next;
  logic [1:0]       verdict_next;
  logic [15:0]      count_next;

  logic             accept;
  logic             hit;
  logic             more;
  logic [31:0]      age;
  logic             expired;
  logic [15:0]      count_inc;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign hit       = (rd_src == req_src);
  assign more      = ((CNT_W'(idx) + CNT_W'(1)) < used);
  assign age       = req_time - rd_data.window_start;
  assign expired   = (age >= cfg.window_seconds);
  assign count_inc = (rd_data.count == COUNT_MAX) ? COUNT_MAX : rd_data.count + 16'd1;

  // Read both memories at the scan index
  always_ff @(posedge clk) begin
    rd_src  <= src_mem[idx];
    rd_data <= data_mem[idx];
  end

  // Write back updated or newly allocated entries
  always_ff @(posedge clk) begin
    if (src_we) begin
      src_mem[wr_addr] <= req_src;
    end
    if (data_we) begin
      data_mem[wr_addr] <= wr_data;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (used == '0) ? ST_MISS : ST_READ;
        end
      end
      ST_READ: state_next = ST_CMP;
      ST_CMP: begin
        if (hit) begin
          state_next = ST_IDLE;
        end else if (more) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_MISS;
        end
      end
      ST_MISS: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath control and result
  always_comb begin
    idx_next     = idx;
    used_next    = used;
    src_we       = 1'b0;
    data_we      = 1'b0;
    wr_addr      = idx;
    wr_data      = '{count: 16'd1, window_start: req_time};
    done_next    = 1'b0;
    verdict_next = VERDICT_ACCEPT;
    count_next   = 16'd1;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          idx_next = '0;
        end
      end
      ST_READ: ;
      ST_CMP: begin
        if (hit) begin
          data_we   = 1'b1;
          done_next = 1'b1;
          if (!expired) begin
            wr_data.count        = count_inc;
            wr_data.window_start = rd_data.window_start;
            count_next           = count_inc;
            if (count_inc > cfg.request_limit) begin
              verdict_next = VERDICT_LIMITED;
            end
          end
        end else if (more) begin
          idx_next = idx + IDX_W'(1);
        end
      end
      ST_MISS: begin
        done_next = 1'b1;
        if (used == FULL) begin
          verdict_next = VERDICT_UNTRACKED;
          count_next   = 16'd0;
        end else begin
          src_we    = 1'b1;
          data_we   = 1'b1;
          wr_addr   = used[IDX_W-1:0];
          used_next = used + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      done  <= done_next;
    end
  end

  // Payload registers: latch the request, advance the scan, hold the result
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (accept) begin
      req_src  <= source_address;
      req_time <= arrival_time;
    end
    if (done_next) begin
      verdict       <= verdict_next;
      request_count <= count_next;
    end
  end

endmodule

### rtl/psrl_checker.sv
// ----------------------------------------------------------------------------
// psrl_checker
// Port-level assertions for the rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
module psrl_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  verdict,
  input logic [15:0] request_count
);
  import psrl_pkg::*;

  // An accepted request keeps the block busy in the next cycle
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // A result ends the lookup: it shows while idle, right after a busy cycle
  assert property (@(posedge clk) disable iff (rst) done |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a lookup");

  // Untracked requests report a zero count
  assert property (@(posedge clk) disable iff (rst)
    (done && verdict == VERDICT_UNTRACKED) |-> (request_count == 16'd0))
    else $error("untracked result with nonzero count");

  // Tracked requests report a nonzero count and a known verdict
  assert property (@(posedge clk) disable iff (rst)
    (done && verdict != VERDICT_UNTRACKED) |->
      (request_count != 16'd0 &&
       (verdict == VERDICT_ACCEPT || verdict == VERDICT_LIMITED)))
    else $error("tracked result with bad count or verdict");

endmodule

bind per_source_request_rate_limiter psrl_checker u_psrl_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .verdict       (verdict),
  .request_count (request_count)
);
